// File: src/clcd_pkg.sv
// Shared types and constants for the character LCD 4-bit command sequencer.
`default_nettype none
package clcd_pkg;

   // Request and response payloads
   typedef struct packed {
      logic [3:0] op;
      logic [5:0] column;
      logic [1:0] row;
      logic [7:0] data_byte;
      logic [2:0] glyph_slot;
   } clcd_req_type;

   typedef struct packed {
      logic        rs;
      logic [3:0]  nibble;
      logic [15:0] wait_before_us;
      logic [15:0] wait_after_us;
      logic        last;
   } clcd_rsp_type;

   // Classified job between front and back
   typedef struct packed {
      logic        is_begin;   // expand into the full init sequence
      logic        rs;
      logic [7:0]  cmd_byte;   // byte to send; for begin, the function set byte
      logic [15:0] wait_after; // wait after the low nibble; for begin, after clear
   } clcd_job_type;

   // Configuration register indexes
   localparam logic CSR_LINE_COUNT = 1'b0;
   localparam logic CSR_CLEAR_WAIT = 1'b1;

   // Operation codes
   localparam logic [3:0] OP_BEGIN        = 4'd0;
   localparam logic [3:0] OP_CLEAR        = 4'd1;
   localparam logic [3:0] OP_HOME         = 4'd2;
   localparam logic [3:0] OP_SET_CURSOR   = 4'd3;
   localparam logic [3:0] OP_WRITE        = 4'd4;
   localparam logic [3:0] OP_CURSOR_ON    = 4'd5;
   localparam logic [3:0] OP_CURSOR_OFF   = 4'd6;
   localparam logic [3:0] OP_BLINK_ON     = 4'd7;
   localparam logic [3:0] OP_BLINK_OFF    = 4'd8;
   localparam logic [3:0] OP_DISPLAY_ON   = 4'd9;
   localparam logic [3:0] OP_DISPLAY_OFF  = 4'd10;
   localparam logic [3:0] OP_SCROLL_LEFT  = 4'd11;
   localparam logic [3:0] OP_SCROLL_RIGHT = 4'd12;
   localparam logic [3:0] OP_AUTO_ON      = 4'd13;
   localparam logic [3:0] OP_AUTO_OFF     = 4'd14;
   localparam logic [3:0] OP_GLYPH_SLOT   = 4'd15;

   // Command bytes and bits
   localparam logic [7:0] CMD_CLEAR      = 8'h01;
   localparam logic [7:0] CMD_HOME       = 8'h02;
   localparam logic [7:0] CMD_ENTRY      = 8'h04;
   localparam logic [7:0] CMD_DISPLAY    = 8'h08;
   localparam logic [7:0] CMD_SHIFT_L    = 8'h18;
   localparam logic [7:0] CMD_SHIFT_R    = 8'h1C;
   localparam logic [7:0] CMD_FUNC       = 8'h20;
   localparam logic [7:0] CMD_TWO_LINE   = 8'h08;
   localparam logic [7:0] CMD_CGRAM      = 8'h40;
   localparam logic [7:0] CMD_DDRAM      = 8'h80;

   localparam logic [2:0] DC_DISPLAY = 3'h4;
   localparam logic [2:0] DC_CURSOR  = 3'h2;
   localparam logic [2:0] DC_BLINK   = 3'h1;
   localparam logic [1:0] EM_LEFT    = 2'h2;
   localparam logic [1:0] EM_SHIFT   = 2'h1;

   // Waits in microseconds
   localparam logic [15:0] INIT_WAIT_US  = 16'd50000;
   localparam logic [15:0] STEP_WAIT_US  = 16'd5000;
   localparam logic [15:0] THIRD_WAIT_US = 16'd1000;

   localparam logic [3:0] BEGIN_STEPS = 4'd12;

   // Start address of each display row
   function automatic logic [6:0] row_base(input logic [1:0] r);
      logic [6:0] b;
      unique case (r)
         2'd0: b = 7'h00;
         2'd1: b = 7'h40;
         2'd2: b = 7'h14;
         2'd3: b = 7'h54;
         default: b = 7'h00;
      endcase
      return b;
   endfunction

endpackage
`default_nettype wire

// File: src/clcd_front.sv
// Front end: accepts requests, keeps mode bits and config, builds jobs for the back end.
`default_nettype none
module clcd_front (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_valid,
   output logic                   req_ready,
   input  clcd_pkg::clcd_req_type req_payload,
   input  wire                    csr_we,
   input  wire                    csr_index,
   input  wire [15:0]             csr_wdata,
   output logic                   job_valid,
   input  wire                    job_ready,
   output clcd_pkg::clcd_job_type job
);
   import clcd_pkg::*;

   logic [2:0]  line_count_ff;
   logic [15:0] clear_wait_ff;
   logic [2:0]  disp_ff, disp_in;
   logic [1:0]  entry_ff, entry_in;

   logic        accept;
   logic [2:0]  row_lim;
   logic [1:0]  row_eff;
   logic [6:0]  addr;
   logic [16:0] clear_sum;
   logic [15:0] clear_sat;

   assign req_ready = job_ready;
   assign job_valid = req_valid;
   assign accept    = req_valid && job_ready;

   // Clamp the row to the last line; zero lines behaves as one
   assign row_lim   = (line_count_ff == 3'd0) ? 3'd0 : line_count_ff - 3'd1;
   assign row_eff   = ({1'b0, req_payload.row} > row_lim) ? row_lim[1:0] : req_payload.row;
   assign addr      = {1'b0, req_payload.column} + row_base(row_eff);

   assign clear_sum = {1'b0, clear_wait_ff} + {1'b0, STEP_WAIT_US};
   assign clear_sat = clear_sum[16] ? 16'hFFFF : clear_sum[15:0];

   always_comb begin
      disp_in       = disp_ff;
      entry_in      = entry_ff;
      job.is_begin  = 1'b0;
      job.rs        = 1'b0;
      job.cmd_byte  = 8'h00;
      job.wait_after = 16'd0;
      unique case (req_payload.op)
         OP_BEGIN: begin
            job.is_begin   = 1'b1;
            job.cmd_byte   = CMD_FUNC | ((line_count_ff > 3'd1) ? CMD_TWO_LINE : 8'h00);
            job.wait_after = clear_sat;
            disp_in        = DC_DISPLAY;
            entry_in       = EM_LEFT;
         end
         OP_CLEAR: begin
            job.cmd_byte   = CMD_CLEAR;
            job.wait_after = clear_wait_ff;
         end
         OP_HOME: begin
            job.cmd_byte   = CMD_HOME;
            job.wait_after = clear_wait_ff;
         end
         OP_SET_CURSOR:   job.cmd_byte = CMD_DDRAM | {1'b0, addr};
         OP_WRITE: begin
            job.rs       = 1'b1;
            job.cmd_byte = req_payload.data_byte;
         end
         OP_SCROLL_LEFT:  job.cmd_byte = CMD_SHIFT_L;
         OP_SCROLL_RIGHT: job.cmd_byte = CMD_SHIFT_R;
         OP_AUTO_ON: begin
            entry_in     = entry_ff | EM_SHIFT;
            job.cmd_byte = CMD_ENTRY | {6'd0, entry_in};
         end
         OP_AUTO_OFF: begin
            entry_in     = entry_ff & EM_LEFT;
            job.cmd_byte = CMD_ENTRY | {6'd0, entry_in};
         end
         OP_GLYPH_SLOT:   job.cmd_byte = CMD_CGRAM | {2'b00, req_payload.glyph_slot, 3'b000};
         OP_CURSOR_ON, OP_CURSOR_OFF, OP_BLINK_ON, OP_BLINK_OFF,
         OP_DISPLAY_ON, OP_DISPLAY_OFF: begin
            priority case (req_payload.op)
               OP_CURSOR_ON:  disp_in = disp_ff | DC_CURSOR;
               OP_CURSOR_OFF: disp_in = disp_ff & ~DC_CURSOR;
               OP_BLINK_ON:   disp_in = disp_ff | DC_BLINK;
               OP_BLINK_OFF:  disp_in = disp_ff & ~DC_BLINK;
               OP_DISPLAY_ON: disp_in = disp_ff | DC_DISPLAY;
               default:       disp_in = disp_ff & ~DC_DISPLAY;
            endcase
            job.cmd_byte = CMD_DISPLAY | {5'd0, disp_in};
         end
         default: job.cmd_byte = 8'h00;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_count_ff <= 3'd2;
         clear_wait_ff <= 16'd1000;
         disp_ff       <= 3'd0;
         entry_ff      <= EM_LEFT;
      end else begin
         if (csr_we && csr_index == CSR_LINE_COUNT) line_count_ff <= csr_wdata[2:0];
         if (csr_we && csr_index == CSR_CLEAR_WAIT) clear_wait_ff <= csr_wdata;
         if (accept) begin
            disp_ff  <= disp_in;
            entry_ff <= entry_in;
         end
      end
   end

endmodule
`default_nettype wire

// File: src/clcd_queue.sv
// Small job queue between front and back end.
`default_nettype none
module clcd_queue #(
   parameter int DEPTH = 4
) (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    in_valid,
   output logic                   in_ready,
   input  clcd_pkg::clcd_job_type in_data,
   output logic                   out_valid,
   input  wire                    out_ready,
   output clcd_pkg::clcd_job_type out_data
);
   import clcd_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   clcd_job_type     mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic             push, pop;

   assign in_ready  = (count_ff != FULL_CNT);
   assign out_valid = (count_ff != '0);
   assign out_data  = mem_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= in_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
         if (pop)  rd_ptr_ff <= (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
         if (push && !pop)      count_ff <= count_ff + 1'b1;
         else if (pop && !push) count_ff <= count_ff - 1'b1;
      end
   end

endmodule
`default_nettype wire

// File: src/clcd_back.sv
// Back end: expands each job into nibble transfers behind an output register.
`default_nettype none
module clcd_back (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    job_valid,
   output logic                   job_ready,
   input  clcd_pkg::clcd_job_type job,
   output logic                   rsp_valid,
   input  wire                    rsp_ready,
   output clcd_pkg::clcd_rsp_type rsp_payload
);
   import clcd_pkg::*;

   logic [3:0]   step_ff;
   logic         rsp_valid_ff;
   clcd_rsp_type rsp_ff, rsp_in;
   logic         emit, is_last;

   assign emit    = job_valid && (!rsp_valid_ff || rsp_ready);
   assign is_last = job.is_begin ? (step_ff == BEGIN_STEPS - 4'd1) : (step_ff == 4'd1);
   assign job_ready = emit && is_last;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   always_comb begin
      rsp_in.rs             = job.rs;
      rsp_in.last           = is_last;
      rsp_in.wait_before_us = 16'd0;
      rsp_in.wait_after_us  = 16'd0;
      rsp_in.nibble         = 4'h0;
      if (job.is_begin) begin
         unique case (step_ff)
            4'd0: begin
               rsp_in.nibble         = 4'h3;
               rsp_in.wait_before_us = INIT_WAIT_US;
               rsp_in.wait_after_us  = STEP_WAIT_US;
            end
            4'd1: begin
               rsp_in.nibble        = 4'h3;
               rsp_in.wait_after_us = STEP_WAIT_US;
            end
            4'd2: begin
               rsp_in.nibble        = 4'h3;
               rsp_in.wait_after_us = THIRD_WAIT_US;
            end
            4'd3: rsp_in.nibble = 4'h2;
            4'd4: rsp_in.nibble = job.cmd_byte[7:4];
            4'd5: begin
               rsp_in.nibble        = job.cmd_byte[3:0];
               rsp_in.wait_after_us = STEP_WAIT_US;
            end
            4'd6: rsp_in.nibble = CMD_DISPLAY[7:4];
            4'd7: begin
               rsp_in.nibble        = CMD_DISPLAY[3:0] | {1'b0, DC_DISPLAY};
               rsp_in.wait_after_us = STEP_WAIT_US;
            end
            4'd8: rsp_in.nibble = CMD_CLEAR[7:4];
            4'd9: begin
               rsp_in.nibble        = CMD_CLEAR[3:0];
               rsp_in.wait_after_us = job.wait_after;
            end
            4'd10: rsp_in.nibble = CMD_ENTRY[7:4];
            4'd11: begin
               rsp_in.nibble        = CMD_ENTRY[3:0] | {2'b00, EM_LEFT};
               rsp_in.wait_after_us = STEP_WAIT_US;
            end
            default: rsp_in.nibble = 4'h0;
         endcase
      end else if (step_ff == 4'd0) begin
         rsp_in.nibble = job.cmd_byte[7:4];
      end else begin
         rsp_in.nibble        = job.cmd_byte[3:0];
         rsp_in.wait_after_us = job.wait_after;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= 4'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (emit) begin
            rsp_valid_ff <= 1'b1;
            step_ff      <= is_last ? 4'd0 : step_ff + 4'd1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

endmodule
`default_nettype wire

// File: src/char_lcd_4bit_command_sequencer_unit.sv
// Top level of the character LCD 4-bit command sequencer.
// A request's first transfer passes the job queue, then the back end's output register.
// Throughput: one transfer per cycle out of the back end unless rsp_ready stalls it; begin
// sends the full init sequence, any other request two nibbles, set by the step counter.
// A request is accepted each cycle while the job queue has room.
// Reset (synchronous): queue empty, display bits off, entry left, two lines, clear wait 1000.
`default_nettype none
module char_lcd_4bit_command_sequencer_unit #(
   parameter int QUEUE_DEPTH = 4
) (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_valid,
   output logic                   req_ready,
   input  clcd_pkg::clcd_req_type req_payload,
   output logic                   rsp_valid,
   input  wire                    rsp_ready,
   output clcd_pkg::clcd_rsp_type rsp_payload,
   input  wire                    csr_we,
   input  wire                    csr_index,
   input  wire [15:0]             csr_wdata
);
   import clcd_pkg::*;

   // Front to queue
   logic         fq_valid, fq_ready;
   clcd_job_type fq_job;
   // Queue to back
   logic         qb_valid, qb_ready;
   clcd_job_type qb_job;

   // Classify each request and update the mode bits as it is accepted
   clcd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .job_valid   (fq_valid),
      .job_ready   (fq_ready),
      .job         (fq_job)
   );

   // Decouple classification from the slow nibble expansion
   clcd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fq_valid),
      .in_ready  (fq_ready),
      .in_data   (fq_job),
      .out_valid (qb_valid),
      .out_ready (qb_ready),
      .out_data  (qb_job)
   );

   // Expand the head job into nibble transfers, high nibble first
   clcd_back u_back (
      .clock       (clock),
      .reset       (reset),
      .job_valid   (qb_valid),
      .job_ready   (qb_ready),
      .job         (qb_job),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule
`default_nettype wire
